// ----- hdl/clbs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clbs_pkg
// Shared constants, codes and types of the crop / letterbox / bilinear scaler.
// ----------------------------------------------------------------------------
package clbs_pkg;

    localparam int MAX_BOX_SIDE_DEF   = 128;
    localparam int MAX_FRAME_SIDE_DEF = 1024;
    localparam int FRAC_BITS_DEF      = 16;

    localparam int COORD_W     = 10;   // pos_col / pos_row / box_left / box_top
    localparam int CH_W        = 8;    // one color channel
    localparam int PIX_W       = 3 * CH_W;
    localparam int BOX_REG_W   = 8;
    localparam int FRAME_REG_W = 11;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;

    // start accept to result strobe, in cycles
    localparam int LATENCY = 6;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_REQ  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_BOX_LEFT         = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_TOP          = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_OUT_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_OUT_HEIGHT = 3'd5;

    // per-word control carried down the request pipeline
    typedef struct packed {
        logic req;      // word is a request that produces a result
        logic pad;      // inside a letterbox bar or outside the frame
        logic inval;    // zero-size box
        logic x_odd;    // parity of left neighbor column
        logic y_odd;    // parity of top neighbor row
        logic x_same;   // right neighbor clamped onto left one
        logic y_same;   // bottom neighbor clamped onto top one
    } t_tag;

    typedef enum logic [6:0] {
        D_IDLE     = 7'b0000001,
        D_FIT_GO   = 7'b0000010,
        D_FIT_WAIT = 7'b0000100,
        D_COL_GO   = 7'b0001000,
        D_COL_WAIT = 7'b0010000,
        D_ROW_GO   = 7'b0100000,
        D_ROW_WAIT = 7'b1000000
    } t_dstate;

endpackage
`default_nettype wire

// ----- hdl/clbs_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clbs_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module clbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ----- hdl/clbs_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clbs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module clbs_div #(
    parameter int DW  = 23,
    parameter int DVW = 11
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [DW-1:0]  i_dividend,
    input  wire logic [DVW-1:0] i_divisor,
    output logic                o_done,
    output logic      [DW-1:0]  o_quot
);

    localparam int CNT_W = $clog2(DW + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [DVW-1:0]   r_rem;
    logic [DW-1:0]    r_quo;
    logic [DVW-1:0]   r_dvs;
    logic             r_done;

    logic [DVW:0]     trial;
    logic             fits;

    assign trial = {r_rem, r_quo[DW-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? DVW'(trial - {1'b0, r_dvs}) : DVW'(trial);
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
`default_nettype wire

// ----- hdl/clbs_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clbs_cfg
// Configuration registers and the fit sequencer that derives fitted size,
// bar width and Q-format step ratios through a shared serial divider.
// ----------------------------------------------------------------------------
module clbs_cfg #(
    parameter int MAX_BOX_SIDE   = clbs_pkg::MAX_BOX_SIDE_DEF,
    parameter int MAX_FRAME_SIDE = clbs_pkg::MAX_FRAME_SIDE_DEF,
    parameter int FRAC_BITS      = clbs_pkg::FRAC_BITS_DEF,
    localparam int BOX_W   = $clog2(MAX_BOX_SIDE + 1),
    localparam int FRAME_W = $clog2(MAX_FRAME_SIDE + 1),
    localparam int BXW     = $clog2(MAX_BOX_SIDE),
    localparam int STEP_W  = BXW + FRAC_BITS
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_we,
    input  wire logic [clbs_pkg::CFG_IDX_W-1:0]   i_index,
    input  wire logic [clbs_pkg::CFG_DATA_W-1:0]  i_data,
    output logic                                  o_busy,
    output logic      [clbs_pkg::COORD_W-1:0]     o_box_left,
    output logic      [clbs_pkg::COORD_W-1:0]     o_box_top,
    output logic      [BOX_W-1:0]                 o_bw,
    output logic      [BOX_W-1:0]                 o_bh,
    output logic      [FRAME_W-1:0]               o_ow,
    output logic      [FRAME_W-1:0]               o_oh,
    output logic      [FRAME_W-1:0]               o_fw,
    output logic      [FRAME_W-1:0]               o_fh,
    output logic      [FRAME_W-1:0]               o_pad,
    output logic                                  o_byw,
    output logic      [STEP_W-1:0]                o_col_step,
    output logic      [STEP_W-1:0]                o_row_step
);

    localparam int PW  = BOX_W + FRAME_W;
    localparam int DW  = (PW > STEP_W) ? PW : STEP_W;
    localparam int DVW = (BOX_W > FRAME_W) ? BOX_W : FRAME_W;

    logic [clbs_pkg::COORD_W-1:0]     r_box_left, r_box_top;
    logic [clbs_pkg::BOX_REG_W-1:0]   r_box_width, r_box_height;
    logic [clbs_pkg::FRAME_REG_W-1:0] r_frame_w, r_frame_h;

    clbs_pkg::t_dstate r_state, n_state;
    logic [FRAME_W-1:0] r_fw, r_fh, r_pad;
    logic               r_byw;
    logic [STEP_W-1:0]  r_col_step, r_row_step;

    logic [BOX_W-1:0]   bw, bh;
    logic [FRAME_W-1:0] ow, oh;
    logic [PW-1:0]      prod_wh, prod_hw;
    logic               byw_c, box_ok, go;

    logic               div_start, div_done;
    logic [DW-1:0]      div_dividend, div_quot;
    logic [DVW-1:0]     div_divisor;
    logic [FRAME_W-1:0] quot_f;

    // effective sizes: box saturates, frame clamps into 1..MAX
    always_comb begin
        bw = (32'(r_box_width) > 32'(MAX_BOX_SIDE)) ? BOX_W'(MAX_BOX_SIDE)
                                                     : BOX_W'(r_box_width);
        bh = (32'(r_box_height) > 32'(MAX_BOX_SIDE)) ? BOX_W'(MAX_BOX_SIDE)
                                                      : BOX_W'(r_box_height);
        if (r_frame_w == '0) begin
            ow = FRAME_W'(1);
        end else if (32'(r_frame_w) > 32'(MAX_FRAME_SIDE)) begin
            ow = FRAME_W'(MAX_FRAME_SIDE);
        end else begin
            ow = FRAME_W'(r_frame_w);
        end
        if (r_frame_h == '0) begin
            oh = FRAME_W'(1);
        end else if (32'(r_frame_h) > 32'(MAX_FRAME_SIDE)) begin
            oh = FRAME_W'(MAX_FRAME_SIDE);
        end else begin
            oh = FRAME_W'(r_frame_h);
        end
    end

    assign box_ok  = (bw != '0) && (bh != '0);
    assign prod_wh = PW'(bw) * PW'(oh);
    assign prod_hw = PW'(bh) * PW'(ow);
    assign byw_c   = prod_wh > prod_hw;
    assign quot_f  = FRAME_W'(div_quot);

    // register writes
    always_comb begin
        go = 1'b0;
        if (i_we) begin
            unique case (i_index)
                clbs_pkg::CFG_BOX_LEFT,
                clbs_pkg::CFG_BOX_TOP,
                clbs_pkg::CFG_BOX_WIDTH,
                clbs_pkg::CFG_BOX_HEIGHT,
                clbs_pkg::CFG_FRAME_OUT_WIDTH,
                clbs_pkg::CFG_FRAME_OUT_HEIGHT: go = 1'b1;
                default:                        go = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_left   <= '0;
            r_box_top    <= '0;
            r_box_width  <= '0;
            r_box_height <= '0;
            r_frame_w    <= clbs_pkg::FRAME_REG_W'(1);
            r_frame_h    <= clbs_pkg::FRAME_REG_W'(1);
        end else if (i_we) begin
            unique case (i_index)
                clbs_pkg::CFG_BOX_LEFT:
                    r_box_left <= i_data[clbs_pkg::COORD_W-1:0];
                clbs_pkg::CFG_BOX_TOP:
                    r_box_top <= i_data[clbs_pkg::COORD_W-1:0];
                clbs_pkg::CFG_BOX_WIDTH:
                    r_box_width <= i_data[clbs_pkg::BOX_REG_W-1:0];
                clbs_pkg::CFG_BOX_HEIGHT:
                    r_box_height <= i_data[clbs_pkg::BOX_REG_W-1:0];
                clbs_pkg::CFG_FRAME_OUT_WIDTH:
                    r_frame_w <= i_data[clbs_pkg::FRAME_REG_W-1:0];
                clbs_pkg::CFG_FRAME_OUT_HEIGHT:
                    r_frame_h <= i_data[clbs_pkg::FRAME_REG_W-1:0];
                default: ;
            endcase
        end
    end

    // fit sequencer
    always_comb begin
        n_state      = r_state;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        unique case (r_state)
            clbs_pkg::D_IDLE: ;
            clbs_pkg::D_FIT_GO: begin
                if (box_ok) begin
                    div_start    = 1'b1;
                    div_dividend = byw_c ? DW'(PW'(ow) * PW'(bh)) : DW'(PW'(oh) * PW'(bw));
                    div_divisor  = byw_c ? DVW'(bw) : DVW'(bh);
                    n_state      = clbs_pkg::D_FIT_WAIT;
                end else begin
                    n_state = clbs_pkg::D_IDLE;
                end
            end
            clbs_pkg::D_FIT_WAIT: begin
                if (div_done) n_state = clbs_pkg::D_COL_GO;
            end
            clbs_pkg::D_COL_GO: begin
                if (r_fw != '0) begin
                    div_start    = 1'b1;
                    div_dividend = DW'(STEP_W'(bw - 1'b1) << FRAC_BITS);
                    div_divisor  = DVW'(r_fw);
                    n_state      = clbs_pkg::D_COL_WAIT;
                end else begin
                    n_state = clbs_pkg::D_ROW_GO;
                end
            end
            clbs_pkg::D_COL_WAIT: begin
                if (div_done) n_state = clbs_pkg::D_ROW_GO;
            end
            clbs_pkg::D_ROW_GO: begin
                if (r_fh != '0) begin
                    div_start    = 1'b1;
                    div_dividend = DW'(STEP_W'(bh - 1'b1) << FRAC_BITS);
                    div_divisor  = DVW'(r_fh);
                    n_state      = clbs_pkg::D_ROW_WAIT;
                end else begin
                    n_state = clbs_pkg::D_IDLE;
                end
            end
            clbs_pkg::D_ROW_WAIT: begin
                if (div_done) n_state = clbs_pkg::D_IDLE;
            end
            default: n_state = clbs_pkg::D_IDLE;
        endcase
        if (go) n_state = clbs_pkg::D_FIT_GO;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= clbs_pkg::D_IDLE;
            r_fw       <= '0;
            r_fh       <= '0;
            r_pad      <= '0;
            r_byw      <= 1'b0;
            r_col_step <= '0;
            r_row_step <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                clbs_pkg::D_FIT_GO: begin
                    r_fw       <= '0;
                    r_fh       <= '0;
                    r_pad      <= '0;
                    r_byw      <= 1'b0;
                    r_col_step <= '0;
                    r_row_step <= '0;
                    if (box_ok) begin
                        r_byw <= byw_c;
                        if (byw_c) r_fw <= ow;
                        else       r_fh <= oh;
                    end
                end
                clbs_pkg::D_FIT_WAIT: begin
                    if (div_done) begin
                        if (r_byw) begin
                            r_fh  <= quot_f;
                            r_pad <= (oh - quot_f) >> 1;
                        end else begin
                            r_fw  <= quot_f;
                            r_pad <= (ow - quot_f) >> 1;
                        end
                    end
                end
                clbs_pkg::D_COL_WAIT: begin
                    if (div_done) r_col_step <= STEP_W'(div_quot);
                end
                clbs_pkg::D_ROW_WAIT: begin
                    if (div_done) r_row_step <= STEP_W'(div_quot);
                end
                default: ;
            endcase
        end
    end

    clbs_div #(
        .DW  (DW),
        .DVW (DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign o_busy     = r_state != clbs_pkg::D_IDLE;
    assign o_box_left = r_box_left;
    assign o_box_top  = r_box_top;
    assign o_bw       = bw;
    assign o_bh       = bh;
    assign o_ow       = ow;
    assign o_oh       = oh;
    assign o_fw       = r_fw;
    assign o_fh       = r_fh;
    assign o_pad      = r_pad;
    assign o_byw      = r_byw;
    assign o_col_step = r_col_step;
    assign o_row_step = r_row_step;

endmodule
`default_nettype wire

// ----- hdl/clbs_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clbs_front
// Input register, load/request decode, position multiply and neighbor
// address generation for the four parity banks.
// ----------------------------------------------------------------------------
module clbs_front #(
    parameter int MAX_BOX_SIDE   = clbs_pkg::MAX_BOX_SIDE_DEF,
    parameter int MAX_FRAME_SIDE = clbs_pkg::MAX_FRAME_SIDE_DEF,
    parameter int FRAC_BITS      = clbs_pkg::FRAC_BITS_DEF,
    localparam int BOX_W   = $clog2(MAX_BOX_SIDE + 1),
    localparam int FRAME_W = $clog2(MAX_FRAME_SIDE + 1),
    localparam int BXW     = $clog2(MAX_BOX_SIDE),
    localparam int STEP_W  = BXW + FRAC_BITS,
    localparam int HALF    = (MAX_BOX_SIDE + 1) / 2,
    localparam int HW      = (HALF > 1) ? $clog2(HALF) : 1,
    localparam int AW      = 2 * HW
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_acc,
    input  wire logic                          i_action,
    input  wire logic [clbs_pkg::COORD_W-1:0]  i_col,
    input  wire logic [clbs_pkg::COORD_W-1:0]  i_row,
    input  wire logic [clbs_pkg::PIX_W-1:0]    i_pix,
    input  wire logic [clbs_pkg::COORD_W-1:0]  i_box_left,
    input  wire logic [clbs_pkg::COORD_W-1:0]  i_box_top,
    input  wire logic [BOX_W-1:0]              i_bw,
    input  wire logic [BOX_W-1:0]              i_bh,
    input  wire logic [FRAME_W-1:0]            i_ow,
    input  wire logic [FRAME_W-1:0]            i_oh,
    input  wire logic [FRAME_W-1:0]            i_fw,
    input  wire logic [FRAME_W-1:0]            i_fh,
    input  wire logic [FRAME_W-1:0]            i_pad,
    input  wire logic                          i_byw,
    input  wire logic [STEP_W-1:0]             i_col_step,
    input  wire logic [STEP_W-1:0]             i_row_step,
    output logic      [3:0]                    o_we,
    output logic      [AW-1:0]                 o_waddr,
    output logic      [clbs_pkg::PIX_W-1:0]    o_wdata,
    output logic      [AW-1:0]                 o_raddr [4],
    output clbs_pkg::t_tag                     o_tag,
    output logic      [FRAC_BITS-1:0]          o_fx,
    output logic      [FRAC_BITS-1:0]          o_fy
);

    localparam int CW  = clbs_pkg::COORD_W;
    localparam int CMP = ((FRAME_W > CW) ? FRAME_W : CW) + 1;
    localparam int PXW = STEP_W + CW;
    localparam int XW  = PXW - FRAC_BITS;

    // stage A: accepted word
    logic                       r_a_valid, r_a_act;
    logic [CW-1:0]              r_a_col, r_a_row;
    logic [clbs_pkg::PIX_W-1:0] r_a_pix;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= i_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_act <= i_action;
        r_a_col <= i_col;
        r_a_row <= i_row;
        r_a_pix <= i_pix;
    end

    // decode
    logic           box_ok, in_box, out_frame, in_bar;
    logic [CW:0]    dc, dr;
    logic [BXW-1:0] lx, ly;
    logic [BXW:0]   lx_e, ly_e;
    logic [CMP-1:0] di, dj;
    logic [CW-1:0]  req_i, req_j;

    always_comb begin
        box_ok = (i_bw != '0) && (i_bh != '0);
        dc     = {1'b0, r_a_col} - {1'b0, i_box_left};
        dr     = {1'b0, r_a_row} - {1'b0, i_box_top};
        in_box = box_ok && !dc[CW] && !dr[CW]
                 && (32'(dc) < 32'(i_bw)) && (32'(dr) < 32'(i_bh));
        lx     = BXW'(dc);
        ly     = BXW'(dr);
        lx_e   = {1'b0, lx};
        ly_e   = {1'b0, ly};

        out_frame = (32'(r_a_col) >= 32'(i_ow)) || (32'(r_a_row) >= 32'(i_oh));
        di        = CMP'(r_a_row) - CMP'(i_pad);
        dj        = CMP'(r_a_col) - CMP'(i_pad);
        if (i_byw) begin
            in_bar = (32'(r_a_row) < 32'(i_pad)) || (32'(di) >= 32'(i_fh));
            req_i  = di[CW-1:0];
            req_j  = r_a_col;
        end else begin
            in_bar = (32'(r_a_col) < 32'(i_pad)) || (32'(dj) >= 32'(i_fw));
            req_i  = r_a_row;
            req_j  = dj[CW-1:0];
        end
    end

    // stage B: store write and request coordinate
    clbs_pkg::t_tag             r_b_tag, n_b_tag;
    logic [CW-1:0]              r_b_i, r_b_j;
    logic [3:0]                 r_b_we, n_b_we;
    logic [AW-1:0]              r_b_waddr;
    logic [clbs_pkg::PIX_W-1:0] r_b_wdata;

    always_comb begin
        n_b_tag       = '0;
        n_b_tag.req   = r_a_valid && (r_a_act == clbs_pkg::ACT_REQ);
        n_b_tag.inval = !box_ok;
        n_b_tag.pad   = box_ok && (out_frame || in_bar);
        n_b_we        = '0;
        if (r_a_valid && (r_a_act == clbs_pkg::ACT_LOAD) && in_box) begin
            n_b_we[{ly[0], lx[0]}] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_tag <= '0;
            r_b_we  <= '0;
        end else begin
            r_b_tag <= n_b_tag;
            r_b_we  <= n_b_we;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_i     <= req_i;
        r_b_j     <= req_j;
        r_b_waddr <= {ly_e[HW:1], lx_e[HW:1]};
        r_b_wdata <= r_a_pix;
    end

    // stage C: fixed-point source position
    clbs_pkg::t_tag r_c_tag;
    logic [PXW-1:0] r_c_xp, r_c_yp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_tag <= '0;
        end else begin
            r_c_tag <= r_b_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c_xp <= PXW'(i_col_step) * PXW'(r_b_j);
        r_c_yp <= PXW'(i_row_step) * PXW'(r_b_i);
    end

    // neighbor selection and bank addresses
    logic [XW-1:0]  xf, yf, xc, yc, bwm1, bhm1;
    logic [BXW-1:0] x0, y0;
    logic [BXW:0]   x0e, y0e, x1e, y1e;
    logic [HW-1:0]  xa [2];
    logic [HW-1:0]  ya [2];

    always_comb begin
        xf   = r_c_xp[PXW-1:FRAC_BITS];
        yf   = r_c_yp[PXW-1:FRAC_BITS];
        bwm1 = XW'(i_bw) - XW'(1);
        bhm1 = XW'(i_bh) - XW'(1);
        xc   = (xf > bwm1) ? bwm1 : xf;
        yc   = (yf > bhm1) ? bhm1 : yf;
        x0   = BXW'(xc);
        y0   = BXW'(yc);
        x0e  = {1'b0, x0};
        y0e  = {1'b0, y0};
        x1e  = x0e + 1'b1;
        y1e  = y0e + 1'b1;
        // even bank holds the even one of the pair, odd bank the odd one
        xa[0] = x1e[HW:1];
        xa[1] = x0e[HW:1];
        ya[0] = y1e[HW:1];
        ya[1] = y0e[HW:1];
        for (int b = 0; b < 4; b++) begin
            o_raddr[b] = {ya[b / 2], xa[b % 2]};
        end
    end

    // stage D: aligned with RAM read data
    clbs_pkg::t_tag       r_d_tag, n_d_tag;
    logic [FRAC_BITS-1:0] r_d_fx, r_d_fy;

    always_comb begin
        n_d_tag        = r_c_tag;
        n_d_tag.x_odd  = x0[0];
        n_d_tag.y_odd  = y0[0];
        n_d_tag.x_same = xc == bwm1;
        n_d_tag.y_same = yc == bhm1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_tag <= '0;
        end else begin
            r_d_tag <= n_d_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_d_fx <= r_c_xp[FRAC_BITS-1:0];
        r_d_fy <= r_c_yp[FRAC_BITS-1:0];
    end

    assign o_we    = r_b_we;
    assign o_waddr = r_b_waddr;
    assign o_wdata = r_b_wdata;
    assign o_tag   = r_d_tag;
    assign o_fx    = r_d_fx;
    assign o_fy    = r_d_fy;

endmodule
`default_nettype wire

// ----- hdl/clbs_blend.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clbs_blend
// Bilinear blend: horizontal weighting stage, then vertical weighting into
// the output register.
// ----------------------------------------------------------------------------
module clbs_blend #(
    parameter int FRAC_BITS = clbs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire clbs_pkg::t_tag             i_tag,
    input  wire logic [FRAC_BITS-1:0]       i_fx,
    input  wire logic [FRAC_BITS-1:0]       i_fy,
    input  wire logic [clbs_pkg::PIX_W-1:0] i_rdata [4],
    output logic                            o_valid,
    output logic      [clbs_pkg::CH_W-1:0]  o_red,
    output logic      [clbs_pkg::CH_W-1:0]  o_green,
    output logic      [clbs_pkg::CH_W-1:0]  o_blue,
    output logic                            o_is_padding,
    output logic                            o_box_invalid
);

    localparam int CH = clbs_pkg::CH_W;
    localparam int WW = FRAC_BITS + 1;
    localparam int TW = CH + FRAC_BITS + 1;
    localparam int SW = TW + FRAC_BITS + 1;
    localparam logic [WW-1:0] ONE = WW'(1) << FRAC_BITS;

    logic [clbs_pkg::PIX_W-1:0] p00, p01, p10, p11;
    logic [WW-1:0]              wx0, wx1;
    logic [TW-1:0]              top [3];
    logic [TW-1:0]              bot [3];

    always_comb begin
        p00 = i_rdata[{i_tag.y_odd, i_tag.x_odd}];
        p01 = i_tag.x_same ? p00 : i_rdata[{i_tag.y_odd, !i_tag.x_odd}];
        p10 = i_rdata[{!i_tag.y_odd, i_tag.x_odd}];
        p11 = i_tag.x_same ? p10 : i_rdata[{!i_tag.y_odd, !i_tag.x_odd}];
        if (i_tag.y_same) begin
            p10 = p00;
            p11 = p01;
        end
        wx1 = WW'(i_fx);
        wx0 = ONE - wx1;
        for (int k = 0; k < 3; k++) begin
            top[k] = TW'(p00[(2 - k) * CH +: CH]) * TW'(wx0)
                   + TW'(p01[(2 - k) * CH +: CH]) * TW'(wx1);
            bot[k] = TW'(p10[(2 - k) * CH +: CH]) * TW'(wx0)
                   + TW'(p11[(2 - k) * CH +: CH]) * TW'(wx1);
        end
    end

    // stage E
    clbs_pkg::t_tag       r_e_tag;
    logic [TW-1:0]        r_e_top [3];
    logic [TW-1:0]        r_e_bot [3];
    logic [FRAC_BITS-1:0] r_e_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_tag <= '0;
        end else begin
            r_e_tag <= i_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e_top <= top;
        r_e_bot <= bot;
        r_e_fy  <= i_fy;
    end

    logic [WW-1:0] wy0, wy1;
    logic [SW-1:0] sum [3];
    logic          blend;

    always_comb begin
        wy1   = WW'(r_e_fy);
        wy0   = ONE - wy1;
        blend = !r_e_tag.pad && !r_e_tag.inval;
        for (int k = 0; k < 3; k++) begin
            sum[k] = SW'(r_e_top[k]) * SW'(wy0) + SW'(r_e_bot[k]) * SW'(wy1);
        end
    end

    // stage F: output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_e_tag.req;
        end
    end

    always_ff @(posedge i_clk) begin
        o_red         <= blend ? sum[0][2 * FRAC_BITS +: CH] : '0;
        o_green       <= blend ? sum[1][2 * FRAC_BITS +: CH] : '0;
        o_blue        <= blend ? sum[2][2 * FRAC_BITS +: CH] : '0;
        o_is_padding  <= r_e_tag.pad;
        o_box_invalid <= r_e_tag.inval;
    end

endmodule
`default_nettype wire

// ----- hdl/crop_letterbox_bilinear_scaler_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// crop_letterbox_bilinear_scaler_top
// Crops an RGB box out of a source frame, fits it into the output frame with
// letterbox bars and answers output pixels by bilinear interpolation.
// ----------------------------------------------------------------------------
// One word is taken per cycle (start high while busy low), loads and
// requests freely mixed. A request returns its pixel on the o_out_* ports
// with o_valid high for exactly one cycle, after passing stages A to F; a
// load returns nothing. There is no back-pressure: the receiver must take
// every strobe. Each configuration write restarts the fit computation,
// which runs up to three divisions through one shared bit-serial divider;
// busy stays high until the computation ends. The box store holds no
// reset value: pixels must be loaded before they are requested.
// ----------------------------------------------------------------------------
//
// Pipeline:
//   A  input register
//   B  load/request decode; loads write the box store here
//   C  step * index multiply (Q FRAC_BITS source position)
//   D  neighbor clamp, bank addresses, RAM read
//   E  horizontal weighting of the four neighbors
//   F  vertical weighting, output register
// The box store is split into four banks by row and column parity, so the
// four neighbors of any position come from four distinct banks in one read.
// Loads write at B, before any later request reads at D; the banks are
// read-first, so an earlier request reading in the same cycle sees old data.

module crop_letterbox_bilinear_scaler_top #(
    parameter int MAX_BOX_SIDE   = clbs_pkg::MAX_BOX_SIDE_DEF,
    parameter int MAX_FRAME_SIDE = clbs_pkg::MAX_FRAME_SIDE_DEF,
    parameter int FRAC_BITS      = clbs_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // command word
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_action,
    input  wire logic [clbs_pkg::COORD_W-1:0]     i_pos_col,
    input  wire logic [clbs_pkg::COORD_W-1:0]     i_pos_row,
    input  wire logic [clbs_pkg::CH_W-1:0]        i_in_red,
    input  wire logic [clbs_pkg::CH_W-1:0]        i_in_green,
    input  wire logic [clbs_pkg::CH_W-1:0]        i_in_blue,
    // configuration
    input  wire logic                             i_cfg_we,
    input  wire logic [clbs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [clbs_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // result word
    output logic                                  o_valid,
    output logic      [clbs_pkg::CH_W-1:0]        o_out_red,
    output logic      [clbs_pkg::CH_W-1:0]        o_out_green,
    output logic      [clbs_pkg::CH_W-1:0]        o_out_blue,
    output logic                                  o_is_padding,
    output logic                                  o_box_invalid
);

    localparam int BOX_W   = $clog2(MAX_BOX_SIDE + 1);
    localparam int FRAME_W = $clog2(MAX_FRAME_SIDE + 1);
    localparam int BXW     = $clog2(MAX_BOX_SIDE);
    localparam int STEP_W  = BXW + FRAC_BITS;
    localparam int HALF    = (MAX_BOX_SIDE + 1) / 2;
    localparam int HW      = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int AW      = 2 * HW;

    // configuration / derived fit
    logic                         cfg_busy, byw;
    logic [clbs_pkg::COORD_W-1:0] box_left, box_top;
    logic [BOX_W-1:0]             bw, bh;
    logic [FRAME_W-1:0]           ow, oh, fw, fh, pad;
    logic [STEP_W-1:0]            col_step, row_step;

    // pipeline
    logic                         acc;
    logic [3:0]                   we;
    logic [AW-1:0]                waddr;
    logic [clbs_pkg::PIX_W-1:0]   wdata;
    logic [AW-1:0]                raddr [4];
    logic [clbs_pkg::PIX_W-1:0]   rdata [4];
    clbs_pkg::t_tag               tag;
    logic [FRAC_BITS-1:0]         fx, fy;

    // a write in flight counts as busy so no word slips past it
    assign busy = cfg_busy || i_cfg_we;
    assign acc  = start && !busy;

    clbs_cfg #(
        .MAX_BOX_SIDE   (MAX_BOX_SIDE),
        .MAX_FRAME_SIDE (MAX_FRAME_SIDE),
        .FRAC_BITS      (FRAC_BITS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (i_cfg_we),
        .i_index    (i_cfg_index),
        .i_data     (i_cfg_data),
        .o_busy     (cfg_busy),
        .o_box_left (box_left),
        .o_box_top  (box_top),
        .o_bw       (bw),
        .o_bh       (bh),
        .o_ow       (ow),
        .o_oh       (oh),
        .o_fw       (fw),
        .o_fh       (fh),
        .o_pad      (pad),
        .o_byw      (byw),
        .o_col_step (col_step),
        .o_row_step (row_step)
    );

    clbs_front #(
        .MAX_BOX_SIDE   (MAX_BOX_SIDE),
        .MAX_FRAME_SIDE (MAX_FRAME_SIDE),
        .FRAC_BITS      (FRAC_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_acc      (acc),
        .i_action   (i_action),
        .i_col      (i_pos_col),
        .i_row      (i_pos_row),
        .i_pix      ({i_in_red, i_in_green, i_in_blue}),
        .i_box_left (box_left),
        .i_box_top  (box_top),
        .i_bw       (bw),
        .i_bh       (bh),
        .i_ow       (ow),
        .i_oh       (oh),
        .i_fw       (fw),
        .i_fh       (fh),
        .i_pad      (pad),
        .i_byw      (byw),
        .i_col_step (col_step),
        .i_row_step (row_step),
        .o_we       (we),
        .o_waddr    (waddr),
        .o_wdata    (wdata),
        .o_raddr    (raddr),
        .o_tag      (tag),
        .o_fx       (fx),
        .o_fy       (fy)
    );

    // bank index = {row parity, column parity}
    for (genvar b = 0; b < 4; b++) begin : g_bank
        clbs_ram #(
            .WIDTH (clbs_pkg::PIX_W),
            .DEPTH (1 << AW)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we[b]),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_raddr (raddr[b]),
            .o_rdata (rdata[b])
        );
    end

    clbs_blend #(
        .FRAC_BITS (FRAC_BITS)
    ) u_blend (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tag         (tag),
        .i_fx          (fx),
        .i_fy          (fy),
        .i_rdata       (rdata),
        .o_valid       (o_valid),
        .o_red         (o_out_red),
        .o_green       (o_out_green),
        .o_blue        (o_out_blue),
        .o_is_padding  (o_is_padding),
        .o_box_invalid (o_box_invalid)
    );

endmodule
`default_nettype wire

// ----- hdl/clbs_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// clbs_chk
// Port-level checker for the scaler, bound to the top level.
// ----------------------------------------------------------------------------
module clbs_chk (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            start,
    input wire logic                            busy,
    input wire logic                            i_action,
    input wire logic                            i_cfg_we,
    input wire logic                            o_valid,
    input wire logic [clbs_pkg::CH_W-1:0]       o_out_red,
    input wire logic [clbs_pkg::CH_W-1:0]       o_out_green,
    input wire logic [clbs_pkg::CH_W-1:0]       o_out_blue,
    input wire logic                            o_is_padding,
    input wire logic                            o_box_invalid
);

    logic black, req_acc;

    assign black   = (o_out_red == '0) && (o_out_green == '0) && (o_out_blue == '0);
    assign req_acc = start && !busy && (i_action == clbs_pkg::ACT_REQ);

    // bars are black and never flagged invalid
    a_pad_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_padding |-> black && !o_box_invalid)
        else $error("padding word not black");

    a_inval_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_box_invalid |-> black)
        else $error("invalid-box word not black");

    // every request comes back after the fixed latency
    a_req_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |-> ##(clbs_pkg::LATENCY) o_valid)
        else $error("request result missing");

    // and nothing else produces a strobe
    a_no_spur: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !req_acc |-> ##(clbs_pkg::LATENCY) !o_valid)
        else $error("spurious result strobe");

    a_cfg_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> busy)
        else $error("busy low right after configuration write");

endmodule

bind crop_letterbox_bilinear_scaler_top clbs_chk u_clbs_chk (.*);
`default_nettype wire

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the crop / letterbox / bilinear scaler: fills the
// crop box with random pixels, then mixes requests with reloads and stray loads under
// several box and frame settings, and checks every returned pixel against a
// bit-exact scoreboard kept alongside the design.
// ----------------------------------------------------------------------------
module tb_top;

    typedef struct packed {
        logic                          act;
        logic [clbs_pkg::COORD_W-1:0]  col;
        logic [clbs_pkg::COORD_W-1:0]  row;
        logic [clbs_pkg::CH_W-1:0]     red;
        logic [clbs_pkg::CH_W-1:0]     green;
        logic [clbs_pkg::CH_W-1:0]     blue;
    } t_word;

    typedef struct packed {
        logic [clbs_pkg::CH_W-1:0] red;
        logic [clbs_pkg::CH_W-1:0] green;
        logic [clbs_pkg::CH_W-1:0] blue;
        logic                      pad;
        logic                      inval;
    } t_pixel;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic                            i_action = clbs_pkg::ACT_LOAD;
    logic [clbs_pkg::COORD_W-1:0]    i_pos_col = '0;
    logic [clbs_pkg::COORD_W-1:0]    i_pos_row = '0;
    logic [clbs_pkg::CH_W-1:0]       i_in_red = '0;
    logic [clbs_pkg::CH_W-1:0]       i_in_green = '0;
    logic [clbs_pkg::CH_W-1:0]       i_in_blue = '0;
    logic                            i_cfg_we = 1'b0;
    logic [clbs_pkg::CFG_IDX_W-1:0]  i_cfg_index = clbs_pkg::CFG_BOX_LEFT;
    logic [clbs_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                            o_valid;
    logic [clbs_pkg::CH_W-1:0]       o_out_red, o_out_green, o_out_blue;
    logic                            o_is_padding, o_box_invalid;

    crop_letterbox_bilinear_scaler_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_action(i_action), .i_pos_col(i_pos_col), .i_pos_row(i_pos_row),
        .i_in_red(i_in_red), .i_in_green(i_in_green), .i_in_blue(i_in_blue),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_out_red(o_out_red), .o_out_green(o_out_green),
        .o_out_blue(o_out_blue), .o_is_padding(o_is_padding),
        .o_box_invalid(o_box_invalid)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // scoreboard state
    t_word       pending_words[$];
    t_pixel      expected_pixels[$];
    logic [23:0] box_store [0:16383];
    longint unsigned box_left, box_top, box_w_reg, box_h_reg, out_w_reg, out_h_reg;
    longint unsigned col_step, row_step, fit_w, fit_h, bar_before;
    bit          width_fit;
    int          accepted_cnt = 0;
    int          mismatch_cnt = 0;
    int          word_cnt = 0;

    function automatic longint unsigned sat_box(longint unsigned v);
        return (v > clbs_pkg::MAX_BOX_SIDE_DEF) ? clbs_pkg::MAX_BOX_SIDE_DEF : v;
    endfunction

    function automatic longint unsigned sat_frame(longint unsigned v);
        if (v == 0) return 1;
        return (v > clbs_pkg::MAX_FRAME_SIDE_DEF) ? clbs_pkg::MAX_FRAME_SIDE_DEF : v;
    endfunction

    function automatic void update_fit();
        longint unsigned bw, bh, ow, oh;
        bw = sat_box(box_w_reg);
        bh = sat_box(box_h_reg);
        ow = sat_frame(out_w_reg);
        oh = sat_frame(out_h_reg);
        col_step = 0; row_step = 0; fit_w = 0; fit_h = 0; bar_before = 0;
        width_fit = 0;
        if (bw == 0 || bh == 0) return;
        if (bw * oh > bh * ow) begin
            width_fit = 1;
            fit_w = ow;
            fit_h = ow * bh / bw;
            bar_before = (oh - fit_h) / 2;
        end else begin
            fit_h = oh;
            fit_w = oh * bw / bh;
            bar_before = (ow - fit_w) / 2;
        end
        if (fit_w != 0) col_step = ((bw - 1) << clbs_pkg::FRAC_BITS_DEF) / fit_w;
        if (fit_h != 0) row_step = ((bh - 1) << clbs_pkg::FRAC_BITS_DEF) / fit_h;
    endfunction

    // apply one accepted word: loads update the store, requests queue a pixel
    function automatic void scale_word(t_word w);
        longint unsigned bw, bh, ow, oh, c, r, i, j, xp, yp, x0, y0, x1, y1;
        longint unsigned fx, fy, one, s;
        logic [23:0] p00, p01, p10, p11;
        logic [7:0]  ch[3];
        t_pixel e;
        bw = sat_box(box_w_reg);
        bh = sat_box(box_h_reg);
        ow = sat_frame(out_w_reg);
        oh = sat_frame(out_h_reg);
        c = 64'(w.col);
        r = 64'(w.row);
        one = 64'd1 << clbs_pkg::FRAC_BITS_DEF;
        if (w.act == clbs_pkg::ACT_LOAD) begin
            if (bw != 0 && bh != 0 && c >= box_left && c - box_left < bw &&
                r >= box_top && r - box_top < bh)
                box_store[(r - box_top) * clbs_pkg::MAX_BOX_SIDE_DEF + (c - box_left)] =
                    {w.red, w.green, w.blue};
            return;
        end
        e = '0;
        if (bw == 0 || bh == 0) begin
            e.inval = 1;
            expected_pixels.push_back(e);
            return;
        end
        if (c >= ow || r >= oh) begin
            e.pad = 1;
            expected_pixels.push_back(e);
            return;
        end
        if (width_fit) begin
            if (r < bar_before || r - bar_before >= fit_h) begin
                e.pad = 1;
                expected_pixels.push_back(e);
                return;
            end
            i = r - bar_before; j = c;
        end else begin
            if (c < bar_before || c - bar_before >= fit_w) begin
                e.pad = 1;
                expected_pixels.push_back(e);
                return;
            end
            i = r; j = c - bar_before;
        end
        xp = col_step * j;
        yp = row_step * i;
        x0 = xp >> clbs_pkg::FRAC_BITS_DEF;
        y0 = yp >> clbs_pkg::FRAC_BITS_DEF;
        fx = xp & (one - 1);
        fy = yp & (one - 1);
        if (x0 > bw - 1) x0 = bw - 1;
        if (y0 > bh - 1) y0 = bh - 1;
        x1 = (x0 + 1 < bw) ? x0 + 1 : bw - 1;
        y1 = (y0 + 1 < bh) ? y0 + 1 : bh - 1;
        p00 = box_store[y0 * clbs_pkg::MAX_BOX_SIDE_DEF + x0];
        p01 = box_store[y0 * clbs_pkg::MAX_BOX_SIDE_DEF + x1];
        p10 = box_store[y1 * clbs_pkg::MAX_BOX_SIDE_DEF + x0];
        p11 = box_store[y1 * clbs_pkg::MAX_BOX_SIDE_DEF + x1];
        for (int k = 0; k < 3; k++) begin
            s = longint'(p00[23-8*k -: 8]) * (one - fx) * (one - fy)
              + longint'(p01[23-8*k -: 8]) * fx * (one - fy)
              + longint'(p10[23-8*k -: 8]) * (one - fx) * fy
              + longint'(p11[23-8*k -: 8]) * fx * fy;
            ch[k] = 8'(s >> (2 * clbs_pkg::FRAC_BITS_DEF));
        end
        e.red = ch[0]; e.green = ch[1]; e.blue = ch[2];
        expected_pixels.push_back(e);
    endfunction

    // driver: one word per handshake, random gaps by stage
    always @(posedge i_clk) begin
        t_word w;
        int    gap_pct;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                scale_word({i_action, i_pos_col, i_pos_row, i_in_red, i_in_green,
                            i_in_blue});
                accepted_cnt++;
            end
            gap_pct = (accepted_cnt < 600) ? 28 : (accepted_cnt < 1200) ? 68 : 0;
            if (!(start && busy)) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= gap_pct) begin
                    w = pending_words.pop_front();
                    i_action   <= w.act;
                    i_pos_col  <= w.col;
                    i_pos_row  <= w.row;
                    i_in_red   <= w.red;
                    i_in_green <= w.green;
                    i_in_blue  <= w.blue;
                    start      <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: every strobe must match the oldest expected pixel
    always @(posedge i_clk) begin
        t_pixel e;
        if (i_rst_n && o_valid) begin
            if (expected_pixels.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("unexpected word: rgb %h %h %h pad %b inval %b",
                             o_out_red, o_out_green, o_out_blue, o_is_padding,
                             o_box_invalid);
            end else begin
                e = expected_pixels.pop_front();
                if (e.red !== o_out_red || e.green !== o_out_green ||
                    e.blue !== o_out_blue || e.pad !== o_is_padding ||
                    e.inval !== o_box_invalid) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("mismatch: exp rgb %h %h %h pad %b inval %b, got %h %h %h pad %b inval %b",
                                 e.red, e.green, e.blue, e.pad, e.inval, o_out_red,
                                 o_out_green, o_out_blue, o_is_padding, o_box_invalid);
                end
            end
        end
    end

    task automatic drain();
        do @(negedge i_clk);
        while (pending_words.size() != 0 || start || expected_pixels.size() != 0);
        repeat (clbs_pkg::LATENCY + 2) @(posedge i_clk);
    endtask

    // write all six registers back to back, only while idle
    task automatic write_regs(int left, int top, int bw, int bh, int ow, int oh);
        int vals[6];
        vals = '{left, top, bw, bh, ow, oh};
        for (int k = 0; k < 6; k++) begin
            @(posedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= clbs_pkg::CFG_IDX_W'(k);
            i_cfg_data  <= clbs_pkg::CFG_DATA_W'(vals[k]);
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        box_left = 64'(left); box_top = 64'(top); box_w_reg = 64'(bw);
        box_h_reg = 64'(bh); out_w_reg = 64'(ow); out_h_reg = 64'(oh);
        update_fit();
    endtask

    function automatic void add_word(bit act, int col, int row);
        t_word w;
        w.act   = act;
        w.col   = clbs_pkg::COORD_W'(col);
        w.row   = clbs_pkg::COORD_W'(row);
        w.red   = clbs_pkg::CH_W'($urandom);
        w.green = clbs_pkg::CH_W'($urandom);
        w.blue  = clbs_pkg::CH_W'($urandom);
        pending_words.push_back(w);
        word_cnt++;
    endfunction

    // one setting: fill the whole box, then a random mix
    task automatic run_setting(int left, int top, int bw, int bh, int ow, int oh,
                               int mix_cnt);
        int ebw, ebh, eow, eoh, pick;
        drain();
        write_regs(left, top, bw, bh, ow, oh);
        ebw = int'(sat_box(64'(bw))); ebh = int'(sat_box(64'(bh)));
        eow = int'(sat_frame(64'(ow))); eoh = int'(sat_frame(64'(oh)));
        if (ebw != 0 && ebh != 0)
            for (int y = 0; y < ebh; y++)
                for (int x = 0; x < ebw; x++)
                    add_word(clbs_pkg::ACT_LOAD, left + x, top + y);
        for (int n = 0; n < mix_cnt; n++) begin
            pick = $urandom_range(99);
            if (pick < 70)
                add_word(clbs_pkg::ACT_REQ,
                         $urandom_range((eow + 1 > 1023) ? 1023 : eow + 1),
                         $urandom_range((eoh + 1 > 1023) ? 1023 : eoh + 1));
            else if (pick < 78)
                add_word(clbs_pkg::ACT_REQ, $urandom_range(1023), $urandom_range(1023));
            else if (pick < 90 && ebw != 0 && ebh != 0)
                add_word(clbs_pkg::ACT_LOAD, left + $urandom_range(ebw - 1),
                         top + $urandom_range(ebh - 1));
            else
                add_word(clbs_pkg::ACT_LOAD, $urandom_range(1023), $urandom_range(1023));
        end
    endtask

    initial begin
        int bw, bh, ow, oh;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed settings
        run_setting(0, 0, 0, 5, 0, 2047, 6);          // zero-size box, frame saturation
        run_setting(3, 9, 4, 0, 10, 10, 4);
        run_setting(1023, 1023, 1, 1, 1024, 1024, 0); // single pixel box at the corner
        add_word(clbs_pkg::ACT_REQ, 0, 0);
        add_word(clbs_pkg::ACT_REQ, 1023, 1023);
        add_word(clbs_pkg::ACT_REQ, 1023, 0);
        run_setting(0, 0, 200, 2, 16, 64, 10);        // oversized width, width-fit
        run_setting(500, 7, 2, 128, 7, 5, 10);        // tall box, height-fit
        run_setting(20, 30, 4, 4, 8, 8, 10);          // aspect tie
        run_setting(0, 0, 128, 1, 1, 1024, 5);        // fitted height rounds to zero
        // random settings, mostly small boxes and frames
        while (word_cnt < 1750) begin
            bw = $urandom_range(1, 10);
            bh = $urandom_range(1, 10);
            case ($urandom_range(9))
                0:       begin ow = 1024; oh = $urandom_range(1, 64); end
                1:       begin ow = $urandom_range(1, 64); oh = 2047; end
                2:       begin ow = 0; oh = $urandom_range(1, 8); end
                3:       begin bw = 0; ow = 32; oh = 32; end
                default: begin ow = $urandom_range(1, 48); oh = $urandom_range(1, 48); end
            endcase
            run_setting($urandom_range(1023 - 10), $urandom_range(1023 - 10),
                        bw, bh, ow, oh, 60);
        end
        drain();
        if (mismatch_cnt == 0 && expected_pixels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end
endmodule

// ----- sim.f -----
hdl/clbs_pkg.sv
hdl/clbs_ram.sv
hdl/clbs_div.sv
hdl/clbs_cfg.sv
hdl/clbs_front.sv
hdl/clbs_blend.sv
hdl/crop_letterbox_bilinear_scaler_top.sv
hdl/clbs_chk.sv
sim/tb_top.sv
